// ===== design/bdqm_pkg.sv =====
package bdqm_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int VAL_W     = 32;
  localparam int CNT_W     = 4;
  localparam int STAT_W    = 2;
  localparam int CMD_W     = 2;
  localparam int FQ_DEPTH  = 2;
  localparam int FQ_AW     = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NO_ROOM  = 2'd2,
    STAT_EMPTY    = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Decoded command beat handed from the front to the back
  typedef struct packed {
    logic                    push;
    logic                    at_front;
    logic signed [VAL_W-1:0] value;
  } item_t;

endpackage

// ===== design/bdqm_front.sv =====
module bdqm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic [1:0]           in_cmd,
  input  logic signed [31:0]   in_value,
  output logic                 in_full,
  output logic                 q_valid,
  output bdqm_pkg::item_t      q_item,
  input  logic                 q_pop
);
  import bdqm_pkg::*;

  item_t              ent_r [FQ_DEPTH];
  logic [FQ_AW-1:0]   wp_r, wp_nxt;
  logic [FQ_AW-1:0]   rp_r, rp_nxt;
  logic [FQ_AW:0]     fill_r, fill_nxt;
  item_t              dec;
  logic               wr_en;
  logic               rd_en;

  // Classify the command into side and direction
  always_comb begin
    dec.value = in_value;
    unique case (cmd_t'(in_cmd))
      CMD_PUSH_BACK: begin
        dec.push = 1'b1;
        dec.at_front = 1'b0;
      end
      CMD_PUSH_FRONT: begin
        dec.push = 1'b1;
        dec.at_front = 1'b1;
      end
      CMD_POP_FRONT: begin
        dec.push = 1'b0;
        dec.at_front = 1'b1;
      end
      default: begin
        dec.push = 1'b0;
        dec.at_front = 1'b0;
      end
    endcase
  end

  assign in_full = (fill_r == (FQ_AW+1)'(FQ_DEPTH));
  assign q_valid = (fill_r != '0);
  assign q_item  = ent_r[rp_r];
  assign wr_en   = in_push && !in_full;
  assign rd_en   = q_pop && q_valid;

  always_comb begin
    wp_nxt   = wr_en ? wp_r + 1'b1 : wp_r;
    rp_nxt   = rd_en ? rp_r + 1'b1 : rp_r;
    fill_nxt = fill_r + (FQ_AW+1)'(wr_en) - (FQ_AW+1)'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_r[wp_r] <= dec;
    end
  end

endmodule

// ===== design/bdqm_back.sv =====
module bdqm_back #(
  parameter int DEPTH = bdqm_pkg::DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  bdqm_pkg::item_t      q_item,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [1:0]           out_status,
  output logic [3:0]           out_count,
  output logic signed [31:0]   out_minimum,
  output logic                 out_min_valid
);
  import bdqm_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic signed [VAL_W-1:0] mem [DEPTH];

  state_t                  state_r, state_nxt;
  logic [AW-1:0]           head_r, head_nxt;
  logic [AW-1:0]           tail_r, tail_nxt;
  logic                    empty_r, empty_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic                    issue_r, issue_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic                    rd_last_r, rd_last_nxt;
  logic                    first_r, first_nxt;
  logic signed [VAL_W-1:0] rd_data_r;
  logic signed [VAL_W-1:0] min_r, min_nxt;
  stat_t                   stat_r, stat_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    mv_r, mv_nxt;

  logic                    out_vld_r, out_vld_nxt;
  stat_t                   o_stat_r;
  logic [CNT_W-1:0]        o_cnt_r;
  logic signed [VAL_W-1:0] o_min_r;
  logic                    o_mv_r;
  logic                    out_load;

  logic                    we;
  logic [AW-1:0]           wa;
  logic [AW:0]             span;

  assign span = {1'b0, tail_nxt} - {1'b0, head_nxt} + (AW+1)'(1);

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    empty_nxt   = empty_r;
    idx_nxt     = idx_r;
    issue_nxt   = 1'b0;
    rd_vld_nxt  = 1'b0;
    rd_last_nxt = 1'b0;
    first_nxt   = first_r;
    min_nxt     = min_r;
    stat_nxt    = stat_r;
    cnt_nxt     = cnt_r;
    mv_nxt      = mv_r;
    q_pop       = 1'b0;
    we          = 1'b0;
    wa          = '0;
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          stat_nxt = STAT_OK;
          if (q_item.push) begin
            if (empty_r) begin
              head_nxt  = '0;
              tail_nxt  = '0;
              empty_nxt = 1'b0;
              we        = 1'b1;
              wa        = '0;
            end else if (q_item.at_front) begin
              if (head_r == '0) begin
                stat_nxt = STAT_NO_ROOM;
              end else begin
                head_nxt = head_r - 1'b1;
                we       = 1'b1;
                wa       = head_r - 1'b1;
              end
            end else begin
              if (tail_r == AW'(DEPTH - 1)) begin
                stat_nxt = STAT_FULL;
              end else begin
                tail_nxt = tail_r + 1'b1;
                we       = 1'b1;
                wa       = tail_r + 1'b1;
              end
            end
          end else begin
            if (empty_r) begin
              stat_nxt = STAT_EMPTY;
            end else if (head_r == tail_r) begin
              head_nxt  = '0;
              tail_nxt  = '0;
              empty_nxt = 1'b1;
            end else if (q_item.at_front) begin
              head_nxt = head_r + 1'b1;
            end else begin
              tail_nxt = tail_r - 1'b1;
            end
          end
          if (empty_nxt) begin
            cnt_nxt   = '0;
            min_nxt   = '0;
            mv_nxt    = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            cnt_nxt   = CNT_W'(span);
            mv_nxt    = 1'b1;
            idx_nxt   = head_nxt;
            issue_nxt = 1'b1;
            first_nxt = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Issue one slot read per cycle, compare the data in the cycle after
        if (issue_r) begin
          rd_vld_nxt  = 1'b1;
          rd_last_nxt = (idx_r == tail_r);
          if (idx_r != tail_r) begin
            issue_nxt = 1'b1;
            idx_nxt   = idx_r + 1'b1;
          end
        end
        if (rd_vld_r) begin
          first_nxt = 1'b0;
          if (first_r || (rd_data_r < min_r)) begin
            min_nxt = rd_data_r;
          end
          if (rd_last_r) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        // Hold until the result register is free
        if (!out_vld_r || out_pop) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_pop && out_vld_r) begin
      out_vld_nxt = 1'b0;
    end
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      head_r    <= '0;
      tail_r    <= '0;
      empty_r   <= 1'b1;
      issue_r   <= 1'b0;
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      empty_r   <= empty_nxt;
      issue_r   <= issue_nxt;
      rd_vld_r  <= rd_vld_nxt;
      rd_last_r <= rd_last_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    first_r <= first_nxt;
    min_r   <= min_nxt;
    stat_r  <= stat_nxt;
    cnt_r   <= cnt_nxt;
    mv_r    <= mv_nxt;
    if (out_load) begin
      o_stat_r <= stat_r;
      o_cnt_r  <= cnt_r;
      o_min_r  <= min_r;
      o_mv_r   <= mv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= q_item.value;
    end
    rd_data_r <= mem[idx_r];
  end

  assign out_empty     = !out_vld_r;
  assign out_status    = o_stat_r;
  assign out_count     = o_cnt_r;
  assign out_minimum   = o_min_r;
  assign out_min_valid = o_mv_r;

`ifndef SYNTH
  a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> (head_r == '0) && (tail_r == '0))
    else $error("indices not cleared while empty");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    !empty_r |-> head_r <= tail_r)
    else $error("head past tail");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !empty_r)
    else $error("scan on empty deque");

  a_rd_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_SCAN))
    else $error("read data outside scan");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    issue_r |-> (idx_r >= head_r) && (idx_r <= tail_r))
    else $error("scan index out of span");
`endif

endmodule

// ===== design/bounded_deque_with_min_unit.sv =====
// Channel   | Handshake         | Beat
// ----------+-------------------+--------------------------------------------
// in        | in_push / in_full | in_cmd, in_value
// out       | out_pop / out_empty | out_status, out_count, out_minimum,
//           |                   | out_min_valid
//
// Each command passes through the back end in order: an update, one read per
// held slot through the single read port of the slot memory, and a load of the
// result register; a command that leaves the deque empty skips the scan.
// A two-beat command queue takes input while the back end is busy or a result
// waits. Reset is synchronous, active low, and leaves the deque empty.
// A stalled result holds the back end in its final state; the queue fills next.
module bounded_deque_with_min_unit #(
  parameter int DEPTH = bdqm_pkg::DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic [1:0]           in_cmd,
  input  logic signed [31:0]   in_value,
  output logic                 in_full,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [1:0]           out_status,
  output logic [3:0]           out_count,
  output logic signed [31:0]   out_minimum,
  output logic                 out_min_valid
);
  import bdqm_pkg::*;

  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  bdqm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_cmd   (in_cmd),
    .in_value (in_value),
    .in_full  (in_full),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  bdqm_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_status    (out_status),
    .out_count     (out_count),
    .out_minimum   (out_minimum),
    .out_min_valid (out_min_valid)
  );

endmodule
